[design/tcspq_pkg.sv]
package tcspq_pkg;

    localparam int NUM_CLASSES = 3;
    localparam int OP_W        = 2;
    localparam int CLASS_W     = 2;
    localparam int VALUE_W     = 32;
    localparam int STATUS_W    = 3;
    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 40;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_FLUSH = 2'd2
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_PUSHED  = 3'd0,
        ST_POPPED  = 3'd1,
        ST_DROPPED = 3'd2,
        ST_NO_DATA = 3'd3,
        ST_FLUSHED = 3'd4
    } status_t;

    // Decision for one operation, handed from the pointer logic to the pipeline
    typedef struct packed {
        status_t              status;
        logic [CLASS_W-1:0]   pop_class;
        logic                 all_empty;
        logic                 wr_en;
        logic                 rd_en;
    } ctrl_dec_t;

endpackage

[design/tcspq_store.sv]
module tcspq_store import tcspq_pkg::*; #(
    parameter int DEPTH  = 48,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Hold read data until the next pop is accepted
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[design/tcspq_ctrl.sv]
module tcspq_ctrl import tcspq_pkg::*; #(
    parameter int QUEUE_DEPTH = 16,
    parameter int ADDR_W      = $clog2(NUM_CLASSES * QUEUE_DEPTH)
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               op_fire,
    input  logic [OP_W-1:0]    operation,
    input  logic [CLASS_W-1:0] class_select,
    output ctrl_dec_t          dec,
    output logic [ADDR_W-1:0]  wr_addr,
    output logic [ADDR_W-1:0]  rd_addr
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [PTR_W-1:0] head_reg  [NUM_CLASSES];
    logic [PTR_W-1:0] head_next [NUM_CLASSES];
    logic [PTR_W-1:0] tail_reg  [NUM_CLASSES];
    logic [PTR_W-1:0] tail_next [NUM_CLASSES];
    logic [CNT_W-1:0] count_reg  [NUM_CLASSES];
    logic [CNT_W-1:0] count_next [NUM_CLASSES];
    logic             found;

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] ptr);
        ring_next = (ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + 1'b1;
    endfunction

    always_comb begin
        head_next     = head_reg;
        tail_next     = tail_reg;
        count_next    = count_reg;
        dec.status    = ST_NO_DATA;
        dec.pop_class = '0;
        dec.wr_en     = 1'b0;
        dec.rd_en     = 1'b0;
        wr_addr       = '0;
        rd_addr       = '0;
        found         = 1'b0;

        case (operation)
            OP_PUSH: begin
                dec.status = ST_DROPPED;
                for (int c = 0; c < NUM_CLASSES; c++) begin
                    if (class_select == CLASS_W'(c)
                        && count_reg[c] != CNT_W'(QUEUE_DEPTH)) begin
                        dec.status    = ST_PUSHED;
                        dec.wr_en     = 1'b1;
                        wr_addr       = ADDR_W'(c * QUEUE_DEPTH) + ADDR_W'(tail_reg[c]);
                        tail_next[c]  = ring_next(tail_reg[c]);
                        count_next[c] = count_reg[c] + 1'b1;
                    end
                end
            end
            OP_POP: begin
                // Lowest-numbered class with data wins
                for (int c = 0; c < NUM_CLASSES; c++) begin
                    if (!found && count_reg[c] != '0) begin
                        found         = 1'b1;
                        dec.status    = ST_POPPED;
                        dec.pop_class = CLASS_W'(c);
                        dec.rd_en     = 1'b1;
                        rd_addr       = ADDR_W'(c * QUEUE_DEPTH) + ADDR_W'(head_reg[c]);
                        head_next[c]  = ring_next(head_reg[c]);
                        count_next[c] = count_reg[c] - 1'b1;
                    end
                end
            end
            OP_FLUSH: begin
                dec.status = ST_FLUSHED;
                for (int c = 0; c < NUM_CLASSES; c++) begin
                    head_next[c]  = '0;
                    tail_next[c]  = '0;
                    count_next[c] = '0;
                end
            end
            default: begin
                dec.status = ST_NO_DATA;
            end
        endcase

        dec.all_empty = 1'b1;
        for (int c = 0; c < NUM_CLASSES; c++) begin
            if (count_next[c] != '0) begin
                dec.all_empty = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < NUM_CLASSES; c++) begin
                head_reg[c]  <= '0;
                tail_reg[c]  <= '0;
                count_reg[c] <= '0;
            end
        end else if (op_fire) begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

endmodule

[design/three_class_strict_priority_queue.sv]
// Stage A registers the decision alongside the storage read; stage B holds the result.
// Throughput: one push, pop or flush per cycle unless the output is backed up;
// the pointer and count update for the three rings is combinational.
// Reset (aresetn low, synchronous) empties all rings and both pipeline stages;
// entry storage is not cleared and needs no clearing pass.
module three_class_strict_priority_queue import tcspq_pkg::*; #(
    parameter int QUEUE_DEPTH = 16,
    parameter int ENTRY_WIDTH = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [1:0] operation, [3:2] class_select, [35:4] entry_value, [39:36] zero
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [2:0] status, [34:3] popped_value, [36:35] popped_class, [37] all_empty,
    // [39:38] zero
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int STORE_W = (ENTRY_WIDTH < VALUE_W) ? ENTRY_WIDTH : VALUE_W;
    localparam int DEPTH   = NUM_CLASSES * QUEUE_DEPTH;
    localparam int ADDR_W  = $clog2(DEPTH);

    logic               s_fire;
    logic               a_advance;
    ctrl_dec_t          dec;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ADDR_W-1:0]  rd_addr;
    logic [STORE_W-1:0] rd_data;

    logic               a_valid_reg;
    status_t            a_status_reg;
    logic [CLASS_W-1:0] a_class_reg;
    logic               a_empty_reg;

    logic               b_valid_reg;
    status_t            b_status_reg;
    logic [VALUE_W-1:0] b_value_reg;
    logic [CLASS_W-1:0] b_class_reg;
    logic               b_empty_reg;

    assign a_advance = a_valid_reg && (!b_valid_reg || m_tready);
    assign s_tready  = !a_valid_reg || a_advance;
    assign s_fire    = s_tvalid && s_tready;

    tcspq_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ADDR_W      (ADDR_W)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .op_fire      (s_fire),
        .operation    (s_tdata[1:0]),
        .class_select (s_tdata[3:2]),
        .dec          (dec),
        .wr_addr      (wr_addr),
        .rd_addr      (rd_addr)
    );

    tcspq_store #(
        .DEPTH  (DEPTH),
        .WIDTH  (STORE_W),
        .ADDR_W (ADDR_W)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (s_fire && dec.wr_en),
        .wr_addr (wr_addr),
        .wr_data (s_tdata[4 +: STORE_W]),
        .rd_en   (s_fire && dec.rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Stage A: decision registered alongside the storage read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (s_fire) begin
            a_valid_reg <= 1'b1;
        end else if (a_advance) begin
            a_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            a_status_reg <= dec.status;
            a_class_reg  <= dec.pop_class;
            a_empty_reg  <= dec.all_empty;
        end
    end

    // Stage B: result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (a_advance) begin
            b_valid_reg <= 1'b1;
        end else if (m_tready) begin
            b_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_advance) begin
            b_status_reg <= a_status_reg;
            b_value_reg  <= (a_status_reg == ST_POPPED) ? VALUE_W'(rd_data) : '0;
            b_class_reg  <= a_class_reg;
            b_empty_reg  <= a_empty_reg;
        end
    end

    assign m_tvalid = b_valid_reg;
    assign m_tdata  = {2'b00, b_empty_reg, b_class_reg, b_value_reg, b_status_reg};

    // Only a popped result carries a value or a class
    assert property (@(posedge aclk) disable iff (!aresetn)
        (b_valid_reg && b_status_reg != ST_POPPED)
            |-> (b_value_reg == '0 && b_class_reg == '0))
        else $error("non-pop result carries payload");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (b_valid_reg && b_status_reg == ST_FLUSHED) |-> b_empty_reg)
        else $error("flush did not leave all rings empty");

    // Input stalls only while the result side is backed up
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (a_valid_reg && b_valid_reg && !m_tready))
        else $error("input stalled without output backpressure");

endmodule
